>>> hw/rtl/odo_pkg.sv
package odo_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_AXLE_TRACK   = 2'd0;
	localparam logic [1:0] REG_WHEEL_RADIUS = 2'd1;
	localparam logic [1:0] REG_HOLES        = 2'd2;

	localparam logic [19:0] AXLE_TRACK_RST   = 20'd9830;
	localparam logic [19:0] WHEEL_RADIUS_RST = 20'd4260;
	localparam logic [9:0]  HOLES_RST        = 10'd20;

	// 2*pi in Q16.16
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

	localparam int CORDIC_STAGES = 24;
	localparam logic signed [26:0] CORDIC_GAIN_INIT = 27'sd10188014;
	localparam logic signed [26:0] SC_ONE           = 27'sd16777216;
	localparam logic signed [26:0] SC_ONE_NEG       = -27'sd16777216;

	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 26;
	localparam int PROD_W  = 66;
	localparam int QUOT_W  = 40;
	localparam int DVS_W   = 30;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_ST_MUL_N,
		S_ST_MUL_PI,
		S_ST_DIV,
		S_ST_DIV_WAIT,
		S_ST_COR_WAIT,
		S_ST_MUL_X,
		S_ST_MUL_Y,
		S_ST_CAP_Y,
		S_AR_MUL_DN,
		S_AR_MUL_HB,
		S_AR_DIV,
		S_AR_DIV_WAIT,
		S_AR_COR0_WAIT,
		S_AR_COR1_WAIT,
		S_AR_MUL_K,
		S_AR_CAP_K,
		S_AR_MUL_DC,
		S_AR_DIV_X,
		S_AR_DIV_X_WAIT,
		S_AR_DIV_Y,
		S_AR_DIV_Y_WAIT,
		S_FINISH
	} odo_state_t;

	typedef enum logic [3:0] {
		MS_NONE,
		MS_NR,
		MS_PI,
		MS_S0,
		MS_C0,
		MS_DNR,
		MS_HB,
		MS_K,
		MS_DC,
		MS_DS
	} odo_mul_t;

	typedef enum logic [1:0] {
		DS_DM,
		DS_FRAC,
		DS_ARC
	} odo_div_t;

	typedef enum logic [3:0] {
		CAP_NONE,
		CAP_MAG_PROD,
		CAP_MAG_QUOT,
		CAP_HEAD,
		CAP_SC0,
		CAP_SC1,
		CAP_DXS,
		CAP_DYS,
		CAP_DXA,
		CAP_DYA,
		CAP_CLEAR
	} odo_cap_t;

	typedef struct packed {
		logic     load_in;
		odo_mul_t mul_sel;
		logic     div_start;
		odo_div_t div_sel;
		logic     cor_start;
		logic     cor_new;
		odo_cap_t cap;
		logic     load_out;
	} odo_cmd_t;

	typedef struct packed {
		logic op;
		logic straight;
		logic div_done;
		logic cor_done;
	} odo_status_t;

	// atan(2^-i) as a binary angle, 2^32 = one turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/odo_if.sv
interface odo_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [15:0] left_holes;
	logic signed [15:0] right_holes;

	modport source (output valid, output op, output left_holes, output right_holes,
		input ready);
	modport sink (input valid, input op, input left_holes, input right_holes,
		output ready);
endinterface

interface odo_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic        [31:0] heading;

	modport source (output valid, output delta_x, output delta_y, output heading,
		input ready);
	modport sink (input valid, input delta_x, input delta_y, input heading,
		output ready);
endinterface

>>> hw/rtl/odo_cordic.sv
module odo_cordic import odo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic        [31:0] angle,
	output logic               done,
	output logic signed [25:0] sin_val,
	output logic signed [25:0] cos_val
);

	logic signed [26:0] x_q, y_q, xs, ys;
	logic signed [33:0] z_q, at;
	logic        [4:0]  idx_q;
	logic               busy_q, done_q, flip_q;
	logic        [31:0] shifted, folded;
	logic signed [25:0] x_cl, y_cl;

	// fold into [-90, 90) degrees, remember the half turn
	assign shifted = angle + 32'h4000_0000;
	assign folded  = shifted[31] ? angle + 32'h8000_0000 : angle;

	assign xs = y_q >>> idx_q;
	assign ys = x_q >>> idx_q;
	assign at = {2'b00, atan_turn(idx_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 5'd1;
				if (idx_q == 5'(CORDIC_STAGES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN_INIT;
			y_q    <= '0;
			z_q    <= {{2{folded[31]}}, folded};
			flip_q <= shifted[31];
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - xs;
				y_q <= y_q + ys;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + xs;
				y_q <= y_q - ys;
				z_q <= z_q + at;
			end
		end
	end

	function automatic logic signed [25:0] clamp_one(input logic signed [26:0] v);
		logic signed [25:0] r;
		if (v > SC_ONE)          r = SC_ONE[25:0];
		else if (v < SC_ONE_NEG) r = SC_ONE_NEG[25:0];
		else                     r = v[25:0];
		return r;
	endfunction

	assign x_cl    = clamp_one(x_q);
	assign y_cl    = clamp_one(y_q);
	assign cos_val = flip_q ? -x_cl : x_cl;
	assign sin_val = flip_q ? -y_cl : y_cl;
	assign done    = done_q;

endmodule

>>> hw/rtl/odo_div.sv
module odo_div import odo_pkg::*; #(
	parameter  int DVD_W = 69,
	localparam int CNT_W = $clog2(DVD_W + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  nbits,
	input  logic [DVS_W-1:0]  divisor,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q, rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [DVS_W+1:0]  trial;
	logic              borrow;

	// restoring division, one quotient bit a cycle, dividend MSB first
	assign trial  = {1'b0, rem_q, dvd_q[DVD_W-1]} - {2'b00, dvs_q};
	assign borrow = trial[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= borrow ? {rem_q[DVS_W-2:0], dvd_q[DVD_W-1]} : trial[DVS_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ~borrow};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hw/rtl/odo_dp.sv
module odo_dp import odo_pkg::*; #(
	parameter int ANGLE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [19:0] cfg_data,
	input  logic               req_op,
	input  logic signed [15:0] req_left,
	input  logic signed [15:0] req_right,
	input  odo_cmd_t           cmd,
	output odo_status_t        status,
	output logic signed [31:0] res_dx,
	output logic signed [31:0] res_dy,
	output logic        [31:0] res_heading
);

	localparam int DVD_W = 37 + ANGLE_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic        [19:0] base_q, radius_q, base_eff;
	logic        [9:0]  holes_q, holes_eff;
	logic        [31:0] heading_q, new_q;
	logic               op_q;
	logic signed [15:0] nl_q, nr_q;
	logic        [PROD_W-1:0]  prod_q, mul_p;
	logic        [MUL_A_W-1:0] mag_q, mul_a;
	logic        [MUL_B_W-1:0] mul_b;
	logic signed [25:0] s0_q, c0_q, s1_q, c1_q, cor_sin, cor_cos;
	logic signed [31:0] dx_q, dy_q, out_dx_q, out_dy_q;
	logic        [31:0] out_hd_q;

	logic signed [16:0] sum_s, dn_s;
	logic        [16:0] sum_mag, dn_mag;
	logic        [15:0] nl_mag;
	logic signed [26:0] dc_s, ds_s;
	logic        [25:0] dc_mag, ds_mag, s0_mag, c0_mag;

	logic [DVD_W-1:0]      dvd;
	logic [CNT_W-1:0]      nbits;
	logic [DVS_W-1:0]      dvs;
	logic                  div_done, cor_done;
	logic [QUOT_W-1:0]     quot;
	logic [ANGLE_BITS-1:0] frac_ab, frac_adj;
	logic [31:0]           head_step;

	assign base_eff  = (base_q == '0) ? 20'd1 : base_q;
	assign holes_eff = (holes_q == '0) ? 10'd1 : holes_q;

	assign sum_s   = {nl_q[15], nl_q} + {nr_q[15], nr_q};
	assign dn_s    = {nl_q[15], nl_q} - {nr_q[15], nr_q};
	assign sum_mag = sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
	assign dn_mag  = dn_s[16] ? 17'(-dn_s) : 17'(dn_s);
	assign nl_mag  = nl_q[15] ? 16'(-nl_q) : 16'(nl_q);

	assign dc_s   = {c0_q[25], c0_q} - {c1_q[25], c1_q};
	assign ds_s   = {s1_q[25], s1_q} - {s0_q[25], s0_q};
	assign dc_mag = dc_s[26] ? 26'(-dc_s) : 26'(dc_s);
	assign ds_mag = ds_s[26] ? 26'(-ds_s) : 26'(ds_s);
	assign s0_mag = s0_q[25] ? 26'(-s0_q) : 26'(s0_q);
	assign c0_mag = c0_q[25] ? 26'(-c0_q) : 26'(c0_q);

	// shared unsigned multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MS_NR: begin
				mul_a = MUL_A_W'(nl_mag);
				mul_b = MUL_B_W'(radius_q);
			end
			MS_PI: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(TWO_PI_Q16);
			end
			MS_S0: begin
				mul_a = mag_q;
				mul_b = s0_mag;
			end
			MS_C0: begin
				mul_a = mag_q;
				mul_b = c0_mag;
			end
			MS_DNR: begin
				mul_a = MUL_A_W'(dn_mag);
				mul_b = MUL_B_W'(radius_q);
			end
			MS_HB: begin
				mul_a = MUL_A_W'(holes_eff);
				mul_b = MUL_B_W'(base_eff);
			end
			MS_K: begin
				mul_a = MUL_A_W'(sum_mag);
				mul_b = MUL_B_W'(base_eff);
			end
			MS_DC: begin
				mul_a = mag_q;
				mul_b = dc_mag;
			end
			MS_DS: begin
				mul_a = mag_q;
				mul_b = ds_mag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// divider operands, dividend left aligned
	always_comb begin
		case (cmd.div_sel)
			DS_DM: begin
				dvd   = {prod_q[54:16], {(DVD_W - 39){1'b0}}};
				nbits = CNT_W'(39);
				dvs   = DVS_W'(holes_eff);
			end
			DS_FRAC: begin
				dvd   = {mag_q[36:0], {ANGLE_BITS{1'b0}}};
				nbits = CNT_W'(DVD_W);
				dvs   = prod_q[DVS_W-1:0];
			end
			DS_ARC: begin
				dvd   = {prod_q[62:25], {(DVD_W - 38){1'b0}}};
				nbits = CNT_W'(38);
				dvs   = DVS_W'(dn_mag);
			end
			default: begin
				dvd   = '0;
				nbits = '0;
				dvs   = '0;
			end
		endcase
	end

	odo_div #(.DVD_W(DVD_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.nbits    (nbits),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot)
	);

	odo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.cor_start),
		.angle   (cmd.cor_new ? new_q : heading_q),
		.done    (cor_done),
		.sin_val (cor_sin),
		.cos_val (cor_cos)
	);

	assign frac_ab   = quot[ANGLE_BITS-1:0];
	assign frac_adj  = dn_s[16] ? -frac_ab : frac_ab;
	assign head_step = 32'(frac_adj) << (32 - ANGLE_BITS);

	function automatic logic [41:0] floor_mag(input logic neg, input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] t;
		t = neg ? p + PROD_W'(24'hFF_FFFF) : p;
		return t[65:24];
	endfunction

	function automatic logic signed [31:0] sat_sm(input logic neg, input logic [41:0] m);
		logic signed [31:0] r;
		if (!neg) r = (m > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
		else      r = (m > 42'h0_8000_0000) ? 32'sh8000_0000 : -m[31:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= AXLE_TRACK_RST;
			radius_q  <= WHEEL_RADIUS_RST;
			holes_q   <= HOLES_RST;
			heading_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AXLE_TRACK:   base_q   <= cfg_data;
					REG_WHEEL_RADIUS: radius_q <= cfg_data;
					REG_HOLES:        holes_q  <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (cmd.load_out) heading_q <= new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= req_op;
			nl_q <= req_left;
			nr_q <= req_right;
		end
		if (cmd.mul_sel != MS_NONE) prod_q <= mul_p;
		case (cmd.cap)
			CAP_MAG_PROD: mag_q <= prod_q[MUL_A_W-1:0];
			CAP_MAG_QUOT: mag_q <= quot;
			CAP_HEAD:     new_q <= heading_q + head_step;
			CAP_SC0: begin
				s0_q <= cor_sin;
				c0_q <= cor_cos;
			end
			CAP_SC1: begin
				s1_q <= cor_sin;
				c1_q <= cor_cos;
			end
			CAP_DXS: dx_q <= sat_sm(nl_q[15] ^ s0_q[25],
				floor_mag(nl_q[15] ^ s0_q[25], prod_q));
			CAP_DYS: begin
				dy_q  <= sat_sm(nl_q[15] ^ c0_q[25],
					floor_mag(nl_q[15] ^ c0_q[25], prod_q));
				new_q <= heading_q;
			end
			CAP_DXA: dx_q <= sat_sm(sum_s[16] ^ dc_s[26] ^ dn_s[16], 42'(quot));
			CAP_DYA: dy_q <= sat_sm(sum_s[16] ^ ds_s[26] ^ dn_s[16], 42'(quot));
			CAP_CLEAR: begin
				dx_q  <= '0;
				dy_q  <= '0;
				new_q <= '0;
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_dx_q <= dx_q;
			out_dy_q <= dy_q;
			out_hd_q <= new_q;
		end
	end

	assign status.op       = op_q;
	assign status.straight = (nl_q == nr_q);
	assign status.div_done = div_done;
	assign status.cor_done = cor_done;

	assign res_dx      = out_dx_q;
	assign res_dy      = out_dy_q;
	assign res_heading = out_hd_q;

endmodule

>>> hw/rtl/odo_ctrl.sv
module odo_ctrl import odo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        out_ready,
	input  odo_status_t status,
	output odo_cmd_t    cmd,
	output logic        in_ready,
	output logic        out_valid
);

	odo_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:          if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (status.op)            state_d = S_CLEAR;
				else if (status.straight) state_d = S_ST_MUL_N;
				else                      state_d = S_AR_MUL_DN;
			end
			S_CLEAR:         state_d = S_FINISH;
			S_ST_MUL_N:      state_d = S_ST_MUL_PI;
			S_ST_MUL_PI:     state_d = S_ST_DIV;
			S_ST_DIV:        state_d = S_ST_DIV_WAIT;
			S_ST_DIV_WAIT:   if (status.div_done) state_d = S_ST_COR_WAIT;
			S_ST_COR_WAIT:   if (status.cor_done) state_d = S_ST_MUL_X;
			S_ST_MUL_X:      state_d = S_ST_MUL_Y;
			S_ST_MUL_Y:      state_d = S_ST_CAP_Y;
			S_ST_CAP_Y:      state_d = S_FINISH;
			S_AR_MUL_DN:     state_d = S_AR_MUL_HB;
			S_AR_MUL_HB:     state_d = S_AR_DIV;
			S_AR_DIV:        state_d = S_AR_DIV_WAIT;
			S_AR_DIV_WAIT:   if (status.div_done) state_d = S_AR_COR0_WAIT;
			S_AR_COR0_WAIT:  if (status.cor_done) state_d = S_AR_COR1_WAIT;
			S_AR_COR1_WAIT:  if (status.cor_done) state_d = S_AR_MUL_K;
			S_AR_MUL_K:      state_d = S_AR_CAP_K;
			S_AR_CAP_K:      state_d = S_AR_MUL_DC;
			S_AR_MUL_DC:     state_d = S_AR_DIV_X;
			S_AR_DIV_X:      state_d = S_AR_DIV_X_WAIT;
			S_AR_DIV_X_WAIT: if (status.div_done) state_d = S_AR_DIV_Y;
			S_AR_DIV_Y:      state_d = S_AR_DIV_Y_WAIT;
			S_AR_DIV_Y_WAIT: if (status.div_done) state_d = S_FINISH;
			S_FINISH:        if (slot_free) state_d = S_IDLE;
			default:         state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.mul_sel = MS_NONE;
		cmd.div_sel = DS_DM;
		cmd.cap     = CAP_NONE;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_CLEAR:     cmd.cap = CAP_CLEAR;
			S_ST_MUL_N:  cmd.mul_sel = MS_NR;
			S_ST_MUL_PI: cmd.mul_sel = MS_PI;
			S_ST_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_DM;
			end
			S_ST_DIV_WAIT: if (status.div_done) begin
				cmd.cap       = CAP_MAG_QUOT;
				cmd.cor_start = 1'b1;
			end
			S_ST_COR_WAIT: if (status.cor_done) cmd.cap = CAP_SC0;
			S_ST_MUL_X: cmd.mul_sel = MS_S0;
			S_ST_MUL_Y: begin
				cmd.cap     = CAP_DXS;
				cmd.mul_sel = MS_C0;
			end
			S_ST_CAP_Y:  cmd.cap = CAP_DYS;
			S_AR_MUL_DN: cmd.mul_sel = MS_DNR;
			S_AR_MUL_HB: begin
				cmd.cap     = CAP_MAG_PROD;
				cmd.mul_sel = MS_HB;
			end
			S_AR_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_FRAC;
			end
			S_AR_DIV_WAIT: if (status.div_done) begin
				cmd.cap       = CAP_HEAD;
				cmd.cor_start = 1'b1;
			end
			S_AR_COR0_WAIT: if (status.cor_done) begin
				cmd.cap       = CAP_SC0;
				cmd.cor_start = 1'b1;
				cmd.cor_new   = 1'b1;
			end
			S_AR_COR1_WAIT: if (status.cor_done) cmd.cap = CAP_SC1;
			S_AR_MUL_K:  cmd.mul_sel = MS_K;
			S_AR_CAP_K:  cmd.cap = CAP_MAG_PROD;
			S_AR_MUL_DC: cmd.mul_sel = MS_DC;
			S_AR_DIV_X, S_AR_DIV_Y: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_ARC;
			end
			S_AR_DIV_X_WAIT: if (status.div_done) begin
				cmd.cap     = CAP_DXA;
				cmd.mul_sel = MS_DS;
			end
			S_AR_DIV_Y_WAIT: if (status.div_done) cmd.cap = CAP_DYA;
			S_FINISH: cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/differential_drive_odometry_core.sv
// Differential-drive odometry engine.
// request channel: one transaction per odometer interval (op = 0) carrying
// signed left and right hole counts, or a heading clear (op = 1).
// response channel: one transaction per request with the interval's delta_x
// and delta_y (Q16.16 metres, saturated) and the new heading (binary angle).
// Configuration: write cfg_data to register cfg_index while cfg_we is high,
// only while the engine is idle (0 axle track, 1 wheel radius, 2 holes per turn).
// Work per request: a clear uses no arithmetic unit, equal counts take one
// divide and one CORDIC run, and a turn takes a heading divide, two CORDIC
// runs and two more divides. One item is in work at a time; the radix-2
// divider and the single CORDIC are shared across its steps. The next
// request is taken the cycle after a result moves to the output register.
// A finished response sits in an output register, so the next request is
// taken while the receiver stalls; a second finished result holds in the
// engine until the output register frees.
// Reset clears the heading to zero and loads the default geometry.
module differential_drive_odometry_core import odo_pkg::*; #(
	parameter int ANGLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	odo_req_if.sink     request,
	odo_res_if.source   response,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	odo_cmd_t    cmd;
	odo_status_t status;

	// sequencer: walks the multiply / divide / CORDIC steps of one item
	odo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.out_ready (response.ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (request.ready),
		.out_valid (response.valid)
	);

	// arithmetic, heading state, configuration and output registers
	odo_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_op      (request.op),
		.req_left    (request.left_holes),
		.req_right   (request.right_holes),
		.cmd         (cmd),
		.status      (status),
		.res_dx      (response.delta_x),
		.res_dy      (response.delta_y),
		.res_heading (response.heading)
	);

endmodule
